[rtl/core/gbf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian basis function evaluator package
// Shared widths, port types, register and code constants, reciprocal table.
// ----------------------------------------------------------------------------
package gbf_pkg;

   // Primitive table depth and the widths that follow from it.
   localparam int MAX_PRIMS = 16;
   localparam int ADDR_W    = (MAX_PRIMS > 1) ? $clog2(MAX_PRIMS) : 1;
   localparam int CNT_W     = $clog2(MAX_PRIMS + 1);

   // Fixed widths of the arithmetic.
   localparam int COORD_W   = 32;
   localparam int D_W       = 33;   // exact offset point - centre
   localparam int SQ_W      = 48;   // square of an offset, Q.16
   localparam int R2_W      = 50;   // sum of three squares
   localparam int ARG_W     = 37;   // alpha * r2 below this bound gives a live exponential
   localparam int T_W       = 21;   // exponent argument t, Q.16, below 32.0
   localparam int FRAC_W    = 16;
   localparam int U_W       = 54;
   localparam int N_W       = 6;
   localparam int E_W       = 33;   // series value, Q1.32
   localparam int K_W       = 4;
   localparam int TERM_W    = 41;
   localparam int SUM_W     = TERM_W + CNT_W;
   localparam int F_W       = 51;   // angular factor, signed Q.16
   localparam int FMAG_W    = F_W - 1;
   localparam int VALUE_W   = 48;
   localparam int PRIM_W    = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [E_W-1:0]   ONE_Q32       = 33'h1_0000_0000;
   localparam logic [F_W-1:0]   ONE_Q16       = 51'h1_0000;
   localparam logic [31:0]      LN2_Q32       = 32'd2977044472;
   localparam logic [E_W-1:0]   LOG2E_Q32     = 33'd6196328019;
   localparam logic [K_W-1:0]   SERIES_TERMS  = 4'd11;
   localparam logic [K_W-1:0]   LAST_TERM     = 4'd1;
   localparam logic [F_W-1:0]   SPH_Z_SCALE   = 51'd3;
   localparam logic [VALUE_W:0] POS_LIMIT     = 49'h0_7FFF_FFFF_FFFF;
   localparam logic [VALUE_W:0] NEG_LIMIT     = 49'h0_8000_0000_0000;

   // Port types.
   typedef logic        [ADDR_W-1:0]    ram_addr_type;
   typedef logic        [3:0]           slot_type;
   typedef logic        [31:0]          uword_type;
   typedef logic signed [31:0]          sword_type;
   typedef logic signed [VALUE_W-1:0]   value_type;
   typedef logic        [CSR_IDX_W-1:0] csr_index_type;

   // Item modes.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   // Register indexes.
   localparam csr_index_type REG_CENTER_X     = 3'd0;
   localparam csr_index_type REG_CENTER_Y     = 3'd1;
   localparam csr_index_type REG_CENTER_Z     = 3'd2;
   localparam csr_index_type REG_ANGULAR_KIND = 3'd3;
   localparam csr_index_type REG_PRIM_COUNT   = 3'd4;

   // Angular kinds.
   localparam logic [3:0] KIND_S      = 4'd0;
   localparam logic [3:0] KIND_PX     = 4'd1;
   localparam logic [3:0] KIND_PY     = 4'd2;
   localparam logic [3:0] KIND_PZ     = 4'd3;
   localparam logic [3:0] KIND_DXX    = 4'd4;
   localparam logic [3:0] KIND_DYY    = 4'd5;
   localparam logic [3:0] KIND_DZZ    = 4'd6;
   localparam logic [3:0] KIND_DXY    = 4'd7;
   localparam logic [3:0] KIND_DXZ    = 4'd8;
   localparam logic [3:0] KIND_DYZ    = 4'd9;
   localparam logic [3:0] KIND_SPH_Z2 = 4'd10;
   localparam logic [3:0] KIND_SPH_XZ = 4'd11;
   localparam logic [3:0] KIND_SPH_YZ = 4'd12;
   localparam logic [3:0] KIND_SPH_X2 = 4'd13;
   localparam logic [3:0] KIND_SPH_XY = 4'd14;

   // floor(2^32 / k) for the series divisors; the quotient it gives is at most one short.
   function automatic logic [E_W-1:0] recip(input logic [K_W-1:0] k);
      logic [E_W-1:0] r;
      case (k)
         4'd1:    r = 33'd4294967296;
         4'd2:    r = 33'd2147483648;
         4'd3:    r = 33'd1431655765;
         4'd4:    r = 33'd1073741824;
         4'd5:    r = 33'd858993459;
         4'd6:    r = 33'd715827882;
         4'd7:    r = 33'd613566756;
         4'd8:    r = 33'd536870912;
         4'd9:    r = 33'd477218588;
         4'd10:   r = 33'd429496729;
         4'd11:   r = 33'd390451572;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/core/gbf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbf_ram #(
   parameter  int WIDTH  = 64,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/core/gaussian_basis_function_eval.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian basis function evaluator
// Contracted Gaussian orbital value at a grid point, fixed point throughout.
// ----------------------------------------------------------------------------
// A load beat (mode 0) writes one primitive, exponent and pre-normalised
// weight, into a table slot and returns nothing. An evaluate beat (mode 1)
// returns one beat holding the contracted value times the configured angular
// factor, saturated to 48 bits with a flag. Each primitive whose exponential
// does not underflow walks an eleven-term Horner series in one series unit,
// each term being a multiply, a reciprocal multiply and a correction; a
// primitive whose exponential underflows skips the series. Primitives are
// read one at a time from a single table RAM. The next beat is accepted as
// soon as the previous evaluation has placed its result in the output
// register, even if that result has not yet been taken. Slots must be loaded
// before they are summed; the table is not cleared at reset. Configuration
// must be written while the block is idle.
// ----------------------------------------------------------------------------
module gaussian_basis_function_eval (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  gbf_pkg::slot_type      req_slot,
   input  gbf_pkg::uword_type     req_prim_exponent,
   input  gbf_pkg::sword_type     req_prim_weight,
   input  gbf_pkg::sword_type     req_point_x,
   input  gbf_pkg::sword_type     req_point_y,
   input  gbf_pkg::sword_type     req_point_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output gbf_pkg::value_type     rsp_value,
   output logic                   rsp_saturated,
   input  logic                   csr_wr_en,
   input  gbf_pkg::csr_index_type csr_index,
   input  gbf_pkg::uword_type     csr_wr_data
);

   import gbf_pkg::*;

   localparam int SMAG_W = SUM_W;
   localparam int SLO    = SMAG_W / 2;
   localparam int SHI    = SMAG_W - SLO;
   localparam int FLO    = FMAG_W / 2;
   localparam int FHI    = FMAG_W - FLO;
   localparam int PP_W   = SHI + FHI;
   localparam int P_W    = SMAG_W + FMAG_W;

   // One-hot sequencer states.
   typedef enum logic [15:0] {
      ST_IDLE = 16'h0001,
      ST_SQ   = 16'h0002,
      ST_R2   = 16'h0004,
      ST_T1   = 16'h0008,
      ST_T2   = 16'h0010,
      ST_U    = 16'h0020,
      ST_G    = 16'h0040,
      ST_HMUL = 16'h0080,
      ST_HREC = 16'h0100,
      ST_HCOR = 16'h0200,
      ST_TERM = 16'h0400,
      ST_ACC  = 16'h0800,
      ST_FAC  = 16'h1000,
      ST_PP   = 16'h2000,
      ST_PSUM = 16'h4000,
      ST_OUT  = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic signed [COORD_W-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [3:0]                angular_kind_ff;
   logic [4:0]                prim_count_ff;

   // Geometry of the current point.
   logic signed [D_W-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [SQ_W-1:0]       sq_x_ff, sq_x_in, sq_y_ff, sq_y_in, sq_z_ff, sq_z_in;
   logic [R2_W-1:0]       r2_ff, r2_in;

   // Primitive loop.
   logic [CNT_W-1:0]  idx_ff, idx_in, cnt_ff, cnt_in;
   logic              big_ff, big_in, ezero_ff, ezero_in;
   logic [63:0]       plo_ff, plo_in;
   logic [ARG_W-1:0]  phi_ff, phi_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [31:0]       f_ff, f_in;
   logic [31:0]       g_ff, g_in;
   logic [E_W-1:0]    e_ff, e_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [31:0]       x_ff, x_in;
   logic [31:0]       q0_ff, q0_in;
   logic signed [TERM_W-1:0] term_ff, term_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;

   // Angular factor and final product.
   logic signed [F_W-1:0] fac_ff, fac_in;
   logic                  neg_ff, neg_in;
   logic [PP_W-1:0]       pp00_ff, pp00_in, pp01_ff, pp01_in;
   logic [PP_W-1:0]       pp10_ff, pp10_in, pp11_ff, pp11_in;
   logic [P_W-1:0]        prod_ff, prod_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_saturated_ff, rsp_saturated_in;

   // Table RAM.
   logic              ram_wr_en;
   logic [PRIM_W-1:0] ram_rd_data;
   logic [31:0]       alpha;
   logic signed [31:0] weight;

   // Combinational working values.
   logic              accept, out_free;
   logic [D_W-1:0]    mag_dx, mag_dy, mag_dz, ca, cb;
   logic              cross_neg;
   logic [65:0]       sqp_x, sqp_y, sqp_z, crossp;
   logic [ARG_W+31:0] full_arg;
   logic [U_W-1:0]    up;
   logic [63:0]       gp;
   logic [64:0]       hp, rp;
   logic [35:0]       qk, rem;
   logic [E_W-1:0]    qv, ev;
   logic signed [65:0] wprod;
   logic [SMAG_W-1:0] smag;
   logic [FMAG_W-1:0] fmag;
   logic [P_W-17:0]   m_full;
   logic [VALUE_W:0]  limit;
   logic              sat;
   logic [VALUE_W-1:0] mag_out;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign ram_wr_en = accept && (req_mode == MODE_LOAD) && (32'(req_slot) < MAX_PRIMS);

   assign alpha  = ram_rd_data[63:32];
   assign weight = ram_rd_data[31:0];

   // The read address follows the next index so that the slot's data is
   // ready in the register in the next cycle, when the primitive is started.
   gbf_ram #(
      .WIDTH (PRIM_W),
      .DEPTH (MAX_PRIMS)
   ) u_prim_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_W'(req_slot)),
      .wr_data ({req_prim_exponent, req_prim_weight}),
      .rd_addr (idx_in[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign mag_dx = dx_ff[D_W-1] ? D_W'(-dx_ff) : D_W'(dx_ff);
   assign mag_dy = dy_ff[D_W-1] ? D_W'(-dy_ff) : D_W'(dy_ff);
   assign mag_dz = dz_ff[D_W-1] ? D_W'(-dz_ff) : D_W'(dz_ff);

   assign sqp_x = 66'(mag_dx) * 66'(mag_dx);
   assign sqp_y = 66'(mag_dy) * 66'(mag_dy);
   assign sqp_z = 66'(mag_dz) * 66'(mag_dz);

   // Operand pair for the cross-product kinds.
   always_comb begin
      case (angular_kind_ff) inside
         KIND_DXY, KIND_SPH_XY: begin
            ca = mag_dx;
            cb = mag_dy;
            cross_neg = dx_ff[D_W-1] ^ dy_ff[D_W-1];
         end
         KIND_DXZ, KIND_SPH_XZ: begin
            ca = mag_dx;
            cb = mag_dz;
            cross_neg = dx_ff[D_W-1] ^ dz_ff[D_W-1];
         end
         default: begin
            ca = mag_dy;
            cb = mag_dz;
            cross_neg = dy_ff[D_W-1] ^ dz_ff[D_W-1];
         end
      endcase
   end

   assign crossp = 66'(ca) * 66'(cb);

   // Exponent argument alpha * r2, assembled from two partial products.
   assign full_arg = {phi_ff, 32'b0} + (ARG_W + 32)'(plo_ff);
   assign up       = U_W'(t_ff) * U_W'(LOG2E_Q32);
   assign gp       = 64'(f_ff) * 64'(LN2_Q32);

   // One Horner term: x = g * e, then x / k by reciprocal and one correction.
   assign hp  = 65'(g_ff) * 65'(e_ff);
   assign rp  = 65'(x_ff) * 65'(recip(k_ff));
   assign qk  = 36'(q0_ff) * 36'(k_ff);
   assign rem = 36'(x_ff) - qk;
   assign qv  = (rem >= 36'(k_ff)) ? E_W'(q0_ff) + E_W'(1) : E_W'(q0_ff);

   assign ev    = ezero_ff ? '0 : (e_ff >> n_ff);
   assign wprod = $signed({{34{weight[31]}}, weight}) * $signed({33'b0, ev});

   assign smag = sum_ff[SUM_W-1] ? SMAG_W'(-sum_ff) : SMAG_W'(sum_ff);
   assign fmag = fac_ff[F_W-1] ? FMAG_W'(-fac_ff) : FMAG_W'(fac_ff);

   // Rescale to Q.32 and clip to the signed 48-bit range.
   assign m_full  = prod_ff[P_W-1:16];
   assign limit   = neg_ff ? NEG_LIMIT : POS_LIMIT;
   assign sat     = (m_full > (P_W - 16)'(limit));
   assign mag_out = sat ? limit[VALUE_W-1:0] : m_full[VALUE_W-1:0];

   always_comb begin
      state_in         = state_ff;
      dx_in            = dx_ff;
      dy_in            = dy_ff;
      dz_in            = dz_ff;
      sq_x_in          = sq_x_ff;
      sq_y_in          = sq_y_ff;
      sq_z_in          = sq_z_ff;
      r2_in            = r2_ff;
      idx_in           = idx_ff;
      cnt_in           = cnt_ff;
      big_in           = big_ff;
      ezero_in         = ezero_ff;
      plo_in           = plo_ff;
      phi_in           = phi_ff;
      t_in             = t_ff;
      n_in             = n_ff;
      f_in             = f_ff;
      g_in             = g_ff;
      e_in             = e_ff;
      k_in             = k_ff;
      x_in             = x_ff;
      q0_in            = q0_ff;
      term_in          = term_ff;
      sum_in           = sum_ff;
      fac_in           = fac_ff;
      neg_in           = neg_ff;
      pp00_in          = pp00_ff;
      pp01_in          = pp01_ff;
      pp10_in          = pp10_ff;
      pp11_in          = pp11_ff;
      prod_in          = prod_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_value_in     = rsp_value_ff;
      rsp_saturated_in = rsp_saturated_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_EVAL)) begin
               dx_in    = D_W'(req_point_x) - D_W'(center_x_ff);
               dy_in    = D_W'(req_point_y) - D_W'(center_y_ff);
               dz_in    = D_W'(req_point_z) - D_W'(center_z_ff);
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            sq_x_in  = sqp_x[SQ_W+15:16];
            sq_y_in  = sqp_y[SQ_W+15:16];
            sq_z_in  = sqp_z[SQ_W+15:16];
            state_in = ST_R2;
         end
         ST_R2: begin
            r2_in  = R2_W'(sq_x_ff) + R2_W'(sq_y_ff) + R2_W'(sq_z_ff);
            sum_in = '0;
            idx_in = '0;
            cnt_in = (32'(prim_count_ff) > MAX_PRIMS) ? CNT_W'(MAX_PRIMS)
                                                      : CNT_W'(prim_count_ff);
            state_in = (cnt_in == '0) ? ST_FAC : ST_T1;
         end
         ST_T1: begin
            big_in   = (alpha != '0) && (r2_ff[R2_W-1:ARG_W] != '0);
            plo_in   = 64'(alpha) * 64'(r2_ff[31:0]);
            phi_in   = ARG_W'(alpha) * ARG_W'(r2_ff[ARG_W-1:32]);
            state_in = ST_T2;
         end
         ST_T2: begin
            ezero_in = big_ff || (full_arg[ARG_W+31:ARG_W] != '0);
            t_in     = full_arg[ARG_W-1:FRAC_W];
            state_in = ezero_in ? ST_TERM : ST_U;
         end
         ST_U: begin
            n_in     = up[U_W-1:48];
            f_in     = up[47:16];
            state_in = ST_G;
         end
         ST_G: begin
            g_in     = gp[63:32];
            e_in     = ONE_Q32;
            k_in     = SERIES_TERMS;
            state_in = ST_HMUL;
         end
         ST_HMUL: begin
            x_in     = hp[63:32];
            state_in = ST_HREC;
         end
         ST_HREC: begin
            q0_in    = rp[63:32];
            state_in = ST_HCOR;
         end
         ST_HCOR: begin
            e_in = ONE_Q32 - qv;
            if (k_ff == LAST_TERM) begin
               state_in = ST_TERM;
            end else begin
               k_in     = k_ff - K_W'(1);
               state_in = ST_HMUL;
            end
         end
         ST_TERM: begin
            term_in  = wprod[TERM_W+23:24];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in = sum_ff + SUM_W'(term_ff);
            idx_in = idx_ff + CNT_W'(1);
            state_in = (idx_in == cnt_ff) ? ST_FAC : ST_T1;
         end
         ST_FAC: begin
            case (angular_kind_ff) inside
               KIND_S:      fac_in = ONE_Q16;
               KIND_PX:     fac_in = F_W'(dx_ff);
               KIND_PY:     fac_in = F_W'(dy_ff);
               KIND_PZ:     fac_in = F_W'(dz_ff);
               KIND_DXX:    fac_in = F_W'(sq_x_ff);
               KIND_DYY:    fac_in = F_W'(sq_y_ff);
               KIND_DZZ:    fac_in = F_W'(sq_z_ff);
               KIND_DXY, KIND_DXZ, KIND_DYZ, KIND_SPH_XZ, KIND_SPH_YZ, KIND_SPH_XY: begin
                  fac_in = cross_neg ? -F_W'(crossp[SQ_W+15:16])
                                     : F_W'(crossp[SQ_W+15:16]);
               end
               KIND_SPH_Z2: fac_in = SPH_Z_SCALE * F_W'(sq_z_ff) - F_W'(r2_ff);
               KIND_SPH_X2: fac_in = F_W'(sq_x_ff) - F_W'(sq_y_ff);
               default:     fac_in = '0;
            endcase
            state_in = ST_PP;
         end
         ST_PP: begin
            neg_in   = sum_ff[SUM_W-1] != fac_ff[F_W-1];
            pp00_in  = PP_W'(smag[SLO-1:0]) * PP_W'(fmag[FLO-1:0]);
            pp01_in  = PP_W'(smag[SLO-1:0]) * PP_W'(fmag[FMAG_W-1:FLO]);
            pp10_in  = PP_W'(smag[SMAG_W-1:SLO]) * PP_W'(fmag[FLO-1:0]);
            pp11_in  = PP_W'(smag[SMAG_W-1:SLO]) * PP_W'(fmag[FMAG_W-1:FLO]);
            state_in = ST_PSUM;
         end
         ST_PSUM: begin
            prod_in = P_W'(pp00_ff) + (P_W'(pp01_ff) << FLO) + (P_W'(pp10_ff) << SLO)
                    + (P_W'(pp11_ff) << (SLO + FLO));
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_value_in     = neg_ff ? -VALUE_W'(mag_out) : VALUE_W'(mag_out);
               rsp_saturated_in = sat;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         center_z_ff     <= '0;
         angular_kind_ff <= KIND_S;
         prim_count_ff   <= 5'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_CENTER_X:     center_x_ff     <= csr_wr_data;
               REG_CENTER_Y:     center_y_ff     <= csr_wr_data;
               REG_CENTER_Z:     center_z_ff     <= csr_wr_data;
               REG_ANGULAR_KIND: angular_kind_ff <= csr_wr_data[3:0];
               REG_PRIM_COUNT:   prim_count_ff   <= csr_wr_data[4:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      dx_ff            <= dx_in;
      dy_ff            <= dy_in;
      dz_ff            <= dz_in;
      sq_x_ff          <= sq_x_in;
      sq_y_ff          <= sq_y_in;
      sq_z_ff          <= sq_z_in;
      r2_ff            <= r2_in;
      idx_ff           <= idx_in;
      cnt_ff           <= cnt_in;
      big_ff           <= big_in;
      ezero_ff         <= ezero_in;
      plo_ff           <= plo_in;
      phi_ff           <= phi_in;
      t_ff             <= t_in;
      n_ff             <= n_in;
      f_ff             <= f_in;
      g_ff             <= g_in;
      e_ff             <= e_in;
      k_ff             <= k_in;
      x_ff             <= x_in;
      q0_ff            <= q0_in;
      term_ff          <= term_in;
      sum_ff           <= sum_in;
      fac_ff           <= fac_in;
      neg_ff           <= neg_in;
      pp00_ff          <= pp00_in;
      pp01_ff          <= pp01_in;
      pp10_ff          <= pp10_in;
      pp11_ff          <= pp11_in;
      prod_ff          <= prod_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_saturated_ff <= rsp_saturated_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule
`default_nettype wire

[rtl/core/gbf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian basis function evaluator checker
// Port-level properties, attached to the top level by a bind.
// ----------------------------------------------------------------------------
module gbf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input gbf_pkg::value_type rsp_value,
   input logic               rsp_saturated
);

   import gbf_pkg::*;

   // A result beat that is not taken holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_saturated))
      else $error("result beat changed while stalled");

   // A clipped result sits exactly on one end of the range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_value == VALUE_W'(POS_LIMIT) || rsp_value == VALUE_W'(NEG_LIMIT))
      else $error("saturated result not at a range limit");

   // No result can appear the cycle after a beat is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared straight after an input beat");

   // The input side only closes after taking a beat.
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("ready dropped without an accepted beat");

endmodule

bind gaussian_basis_function_eval gbf_checker u_gbf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_value     (rsp_value),
   .rsp_saturated (rsp_saturated)
);
`default_nettype wire
